// ===== rtl/core/xaf_pkg.sv =====
// xaf_pkg: shared types, operation and size codes, and helpers for the x86 alu
// with status flags. No dependencies; every other file in rtl/core imports it.
package xaf_pkg;

    localparam int unsigned DATA_W = 32;

    // operation codes
    localparam logic [3:0] OP_INC = 4'd0;
    localparam logic [3:0] OP_DEC = 4'd1;
    localparam logic [3:0] OP_ADD = 4'd2;
    localparam logic [3:0] OP_SUB = 4'd3;
    localparam logic [3:0] OP_CMP = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_OR  = 4'd7;
    localparam logic [3:0] OP_ADC = 4'd8;
    localparam logic [3:0] OP_SBB = 4'd9;

    // operand size codes
    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_WORD  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;

    localparam logic [DATA_W-1:0] MASK_BYTE  = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_WORD  = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_DWORD = 32'hFFFF_FFFF;

    // request word
    typedef struct packed {
        logic [3:0]        req_type;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [1:0]        size_sel;
        logic              carry_in;
    } req_t;

    // result word
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              carry_flag;
        logic              overflow_flag;
        logic              zero_flag;
        logic              sign_flag;
        logic              parity_flag;
    } rsp_t;

    // operand mask for a size code; the unused code acts as dword
    function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
        logic [DATA_W-1:0] m;
        unique case (size)
            SZ_BYTE: m = MASK_BYTE;
            SZ_WORD: m = MASK_WORD;
            default: m = MASK_DWORD;
        endcase
        return m;
    endfunction

    // top bit of a value at the operand size (with carry_pos, bit 8, 16 or 32 of a carry word gives carry out)
    function automatic logic top_bit(input logic [DATA_W:0] v, input logic [1:0] size,
                                     input logic carry_pos);
        logic b;
        unique case (size)
            SZ_BYTE: b = carry_pos ? v[8]  : v[7];
            SZ_WORD: b = carry_pos ? v[16] : v[15];
            default: b = carry_pos ? v[32] : v[31];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/xaf_if.sv =====
// xaf_req_if and xaf_rsp_if: valid/ready channels carrying one request or result word.
// Depends on xaf_pkg for the word types.
interface xaf_req_if import xaf_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xaf_rsp_if import xaf_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/xaf_stage.sv =====
// xaf_stage: one valid/ready register stage that holds a word and takes a new one
// in the cycle its current word leaves. Depends on xaf_pkg for the default width.
module xaf_stage import xaf_pkg::*; #(
    parameter int unsigned Width = DATA_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [Width-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [Width-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [Width-1:0] data_reg;

    // empty or draining this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload loads on every accepted word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/xaf_exec.sv =====
// xaf_exec: combinational alu core; add, subtract and logic at byte/word/dword size
// with CF, OF, ZF, SF and PF. Depends on xaf_pkg.
module xaf_exec import xaf_pkg::*; (
    input  req_t req,
    output rsp_t rsp
);

    always_comb
    begin
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W:0]   sum;
        logic [DATA_W:0]   dif;
        logic [DATA_W-1:0] r;
        logic              cadd;
        logic              is_add;
        logic              is_sub;
        logic              keep_cf;
        logic              cf;
        logic              of;

        mask    = size_mask(req.size_sel);
        a       = req.operand_a & mask;
        b       = req.operand_b & mask;
        cadd    = 1'b0;
        is_add  = 1'b0;
        is_sub  = 1'b0;
        keep_cf = 1'b0;
        r       = '0;
        cf      = req.carry_in;
        of      = 1'b0;

        // decode
        unique case (req.req_type)
            OP_INC:
            begin
                b       = {{(DATA_W-1){1'b0}}, 1'b1};
                is_add  = 1'b1;
                keep_cf = 1'b1;
            end
            OP_DEC:
            begin
                b       = {{(DATA_W-1){1'b0}}, 1'b1};
                is_sub  = 1'b1;
                keep_cf = 1'b1;
            end
            OP_ADD: is_add = 1'b1;
            OP_SUB, OP_CMP: is_sub = 1'b1;
            OP_AND:
            begin
                r  = a & b;
                cf = 1'b0;
            end
            OP_XOR:
            begin
                r  = a ^ b;
                cf = 1'b0;
            end
            OP_OR:
            begin
                r  = a | b;
                cf = 1'b0;
            end
            OP_ADC:
            begin
                is_add = 1'b1;
                cadd   = req.carry_in;
            end
            OP_SBB:
            begin
                is_sub = 1'b1;
                cadd   = req.carry_in;
            end
            default: r = '0;
        endcase

        // operands are zero above the size, so bit 32 of the difference is the borrow
        sum = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cadd};
        dif = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cadd};

        if (is_add)
        begin
            r  = sum[DATA_W-1:0] & mask;
            of = top_bit({1'b0, (a ^ r) & (b ^ r)}, req.size_sel, 1'b0);
            if (!keep_cf)
            begin
                cf = top_bit(sum, req.size_sel, 1'b1);
            end
        end
        else if (is_sub)
        begin
            r  = dif[DATA_W-1:0] & mask;
            of = top_bit({1'b0, (a ^ b) & (a ^ r)}, req.size_sel, 1'b0);
            if (!keep_cf)
            begin
                cf = dif[DATA_W];
            end
        end

        rsp.result        = r;
        rsp.carry_flag    = cf;
        rsp.overflow_flag = of;
        rsp.zero_flag     = (r == '0);
        rsp.sign_flag     = top_bit({1'b0, r}, req.size_sel, 1'b0);
        rsp.parity_flag   = ~^r[7:0];
    end

endmodule

// ===== rtl/core/x86_alu_flags_top.sv =====
// x86_alu_flags_top: x86 integer alu with status flags, request register, alu, result register.
// Throughput: one word per cycle while rsp.ready is high; the alu sits between two register
// stages and the result stage takes a new word in the cycle its current word is taken.
// Reset (rst_n low, async): both stages empty, req.ready high, rsp.valid low.
// Depends on xaf_pkg, xaf_if, xaf_stage and xaf_exec.
module x86_alu_flags_top import xaf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    xaf_req_if.sink    req,
    xaf_rsp_if.source  rsp
);

    logic                  s1_valid;
    logic                  s1_ready;
    logic [$bits(req_t)-1:0] s1_bits;
    req_t                  s1_req;
    rsp_t                  exec_rsp;
    logic [$bits(rsp_t)-1:0] s2_bits;

    // request register
    xaf_stage #(
        .Width ($bits(req_t))
    ) u_req_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_data   (req.data),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_bits)
    );

    assign s1_req = req_t'(s1_bits);

    // alu and flags
    xaf_exec u_exec (
        .req (s1_req),
        .rsp (exec_rsp)
    );

    // result register
    xaf_stage #(
        .Width ($bits(rsp_t))
    ) u_rsp_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (exec_rsp),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (s2_bits)
    );

    assign rsp.data = rsp_t'(s2_bits);

    // accepted request shows up in the request register
    a_req_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid)
        else $error("accepted request word lost");

    // word moving out of the request register shows up on rsp
    a_rsp_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_ready) |=> rsp.valid)
        else $error("request word did not reach result register");

    // logic ops clear CF and OF
    a_logic_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && (s1_req.req_type == OP_AND || s1_req.req_type == OP_XOR ||
                      s1_req.req_type == OP_OR))
        |-> (!exec_rsp.carry_flag && !exec_rsp.overflow_flag))
        else $error("logic op left CF or OF set");

    // inc and dec keep the incoming carry
    a_incdec_cf: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && (s1_req.req_type == OP_INC || s1_req.req_type == OP_DEC))
        |-> (exec_rsp.carry_flag == s1_req.carry_in))
        else $error("inc/dec changed CF");

    // result is zero above the operand size
    a_result_masked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |-> ((exec_rsp.result & ~size_mask(s1_req.size_sel)) == '0))
        else $error("result has bits above operand size");

endmodule

// ===== bench/testbench.sv =====
// testbench: random and directed check of x86_alu_flags_top, alu results and status flags.
// Depends on xaf_pkg, xaf_if and the rtl files under the top level.
// A scoreboard predicts each word from the accepted request and compares in order.
import xaf_pkg::*;

class alu_scoreboard;
    rsp_t expected_words[$];
    int   errors;

    function new();
        errors = 0;
    endfunction

    // flags and masked result that one request word should give
    function rsp_t compute_flags(req_t w);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] msb;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [DATA_W:0]   wide;
        logic              cf;
        logic              of;
        logic              carry_add;
        logic              is_add;
        logic              is_sub;
        rsp_t              o;
        case (w.size_sel)
            SZ_BYTE:
            begin
                mask = MASK_BYTE;
                msb  = 32'h0000_0080;
            end
            SZ_WORD:
            begin
                mask = MASK_WORD;
                msb  = 32'h0000_8000;
            end
            // the unused size code acts as dword
            default:
            begin
                mask = MASK_DWORD;
                msb  = 32'h8000_0000;
            end
        endcase
        a         = w.operand_a & mask;
        b         = w.operand_b & mask;
        r         = '0;
        cf        = w.carry_in;
        of        = 1'b0;
        carry_add = 1'b0;
        is_add    = 1'b0;
        is_sub    = 1'b0;
        case (w.req_type)
            OP_INC:
            begin
                b      = 32'd1;
                is_add = 1'b1;
            end
            OP_DEC:
            begin
                b      = 32'd1;
                is_sub = 1'b1;
            end
            OP_ADD: is_add = 1'b1;
            OP_SUB, OP_CMP: is_sub = 1'b1;
            OP_AND:
            begin
                r  = a & b;
                cf = 1'b0;
            end
            OP_XOR:
            begin
                r  = a ^ b;
                cf = 1'b0;
            end
            OP_OR:
            begin
                r  = a | b;
                cf = 1'b0;
            end
            OP_ADC:
            begin
                is_add    = 1'b1;
                carry_add = w.carry_in;
            end
            OP_SBB:
            begin
                is_sub    = 1'b1;
                carry_add = w.carry_in;
            end
            // unused codes give zero and keep the carry
            default: r = '0;
        endcase
        if (is_add)
        begin
            wide = {1'b0, a} + {1'b0, b} + carry_add;
            r    = wide[DATA_W-1:0] & mask;
            of   = |((a ^ r) & (b ^ r) & msb);
            if (w.req_type != OP_INC)
                cf = (wide > {1'b0, mask});
        end
        else if (is_sub)
        begin
            r  = (a - b - carry_add) & mask;
            of = |((a ^ b) & (a ^ r) & msb);
            if (w.req_type != OP_DEC)
                cf = ({1'b0, a} < ({1'b0, b} + carry_add));
        end
        o.result        = r;
        o.carry_flag    = cf;
        o.overflow_flag = of;
        o.zero_flag     = (r == '0);
        o.sign_flag     = |(r & msb);
        o.parity_flag   = ~^r[7:0];
        return o;
    endfunction

    function void note_request(req_t w);
        expected_words.push_back(compute_flags(w));
    endfunction

    // one line per mismatch, capped to keep the log short
    task report(string msg);
        if (errors < 100)
            $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_result(rsp_t got);
        rsp_t want;
        if (expected_words.size() == 0)
        begin
            report($sformatf("result word %h arrived with nothing pending", got.result));
            return;
        end
        want = expected_words.pop_front();
        if (got.result !== want.result)
            report($sformatf("result got %h want %h", got.result, want.result));
        if (got.carry_flag !== want.carry_flag)
            report($sformatf("cf got %b want %b (result %h)", got.carry_flag,
                             want.carry_flag, want.result));
        if (got.overflow_flag !== want.overflow_flag)
            report($sformatf("of got %b want %b (result %h)", got.overflow_flag,
                             want.overflow_flag, want.result));
        if (got.zero_flag !== want.zero_flag)
            report($sformatf("zf got %b want %b (result %h)", got.zero_flag,
                             want.zero_flag, want.result));
        if (got.sign_flag !== want.sign_flag)
            report($sformatf("sf got %b want %b (result %h)", got.sign_flag,
                             want.sign_flag, want.result));
        if (got.parity_flag !== want.parity_flag)
            report($sformatf("pf got %b want %b (result %h)", got.parity_flag,
                             want.parity_flag, want.result));
    endtask

    function int outstanding();
        return expected_words.size();
    endfunction
endclass

module testbench;
    localparam int N_RANDOM       = 1330;
    localparam int QUIET_FROM     = N_RANDOM - 200;
    localparam int HOLD_AT        = 120;
    localparam int HOLD_CYCLES    = 60;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    bit   quiet;
    bit   hold_pending;

    alu_scoreboard sb;

    xaf_req_if req_bus ();
    xaf_rsp_if rsp_bus ();

    x86_alu_flags_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // record accepted requests and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && req_bus.valid && req_bus.ready)
            sb.note_request(req_bus.data);
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.data);
    end

    // offer one request word until it is taken
    task send_word(req_t w);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= w;
        do
            @(posedge clk);
        while (!req_bus.ready);
    endtask

    task send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [1:0] size,
                 logic cin);
        req_t w;
        w.req_type  = op;
        w.operand_a = a;
        w.operand_b = b;
        w.size_sel  = size;
        w.carry_in  = cin;
        send_word(w);
    endtask

    // result side: short random stalls, one long hold-off on request
    task drive_ready();
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
        end
    endtask

    // end the run if no word moves on either side for too long
    task watchdog();
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    endtask

    // operand mix: edges of each size, tiny values, and full random
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 13))
            0: v = 32'h0000_0000;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h0000_007F;
            3: v = 32'h0000_0080;
            4: v = 32'h0000_00FF;
            5: v = 32'h0000_7FFF;
            6: v = 32'h0000_8000;
            7: v = 32'h7FFF_FFFF;
            8: v = 32'h8000_0000;
            9: v = $urandom_range(0, 3);
            default: v = $urandom;
        endcase
        // stray upper bits on a quarter of the picked values
        if ($urandom_range(0, 3) == 0)
            v = v | ($urandom & 32'hFFFF_0000);
        return v;
    endfunction

    function automatic logic [3:0] pick_op();
        int x;
        x = $urandom_range(0, 31);
        if (x < 29)
            return 4'(x % 10);
        return 4'($urandom_range(10, 15));
    endfunction

    function automatic logic [1:0] pick_size();
        if ($urandom_range(0, 15) == 0)
            return 2'd3;
        return 2'($urandom_range(0, 2));
    endfunction

    initial
    begin
        sb = new();
        quiet = 1'b0;
        hold_pending = 1'b0;
        rst_n         <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;
        rsp_bus.ready <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        fork
            drive_ready();
            watchdog();
        join_none

        // directed: carries, overflows, zero results, every operation
        send_op(OP_ADD, 32'h0000_007F, 32'h0000_0001, SZ_BYTE, 1'b0);
        send_op(OP_ADD, 32'hABCD_00FF, 32'h1234_0001, SZ_BYTE, 1'b1);
        send_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_DWORD, 1'b0);
        send_op(OP_SUB, 32'h0000_8000, 32'h0000_0001, SZ_WORD, 1'b0);
        send_op(OP_SUB, 32'h0000_0000, 32'h0000_0001, SZ_BYTE, 1'b1);
        send_op(OP_CMP, 32'h0000_0000, 32'hFFFF_FFFF, SZ_DWORD, 1'b0);
        send_op(OP_CMP, 32'h1234_5678, 32'h1234_5678, SZ_DWORD, 1'b1);
        send_op(OP_INC, 32'h0000_007F, 32'hFFFF_FFFF, SZ_BYTE, 1'b1);
        send_op(OP_INC, 32'h0000_00FF, 32'h0000_0000, SZ_BYTE, 1'b0);
        send_op(OP_INC, 32'hFFFF_FFFF, 32'h0000_0000, SZ_DWORD, 1'b1);
        send_op(OP_DEC, 32'h0000_8000, 32'h5555_5555, SZ_WORD, 1'b1);
        send_op(OP_DEC, 32'h0000_0000, 32'h0000_0000, SZ_DWORD, 1'b0);
        send_op(OP_AND, 32'hFFFF_FFFF, 32'h8000_00F0, SZ_DWORD, 1'b1);
        send_op(OP_XOR, 32'hFFFF_1234, 32'hAAAA_1234, SZ_WORD, 1'b1);
        send_op(OP_OR,  32'hFF00_0000, 32'h0000_0003, SZ_BYTE, 1'b1);
        send_op(OP_ADC, 32'hFFFF_FFFF, 32'h0000_0000, SZ_DWORD, 1'b1);
        send_op(OP_ADC, 32'h0000_007F, 32'h0000_0000, SZ_BYTE, 1'b1);
        send_op(OP_SBB, 32'h0000_0000, 32'h0000_FFFF, SZ_WORD, 1'b1);
        send_op(OP_SBB, 32'h0000_0080, 32'h0000_0000, SZ_BYTE, 1'b1);
        send_op(OP_SBB, 32'h0000_0005, 32'h0000_0005, SZ_BYTE, 1'b0);
        send_op(4'd10,  32'hDEAD_BEEF, 32'h1234_5678, SZ_DWORD, 1'b1);
        send_op(4'd15,  32'hFFFF_FFFF, 32'hFFFF_FFFF, SZ_BYTE, 1'b0);
        send_op(OP_ADD, 32'h8000_0000, 32'h8000_0000, 2'd3, 1'b0);
        send_op(OP_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1'b1);

        // random words; one long result stall early, no idling near the end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            req_t w;
            if (i == HOLD_AT)
                hold_pending = 1'b1;
            if (i == QUIET_FROM)
                quiet = 1'b1;
            w.req_type  = pick_op();
            w.operand_a = pick_operand();
            w.operand_b = pick_operand();
            w.size_sel  = pick_size();
            w.carry_in  = 1'($urandom_range(0, 1));
            send_word(w);
        end
        req_bus.valid <= 1'b0;

        // drain, then give the block time to show any stray word
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d result words never arrived", sb.outstanding()));

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
